@@ design/src_pkg.sv @@
// Shared types, widths, register indexes and saturation for the sphere/rectangle collider.
// No dependencies; imported by sphere_rectangle_collide only.
`default_nettype none

package src_pkg;

	localparam int VAL_W         = 24;           // coordinate width, signed
	localparam int CFG_W         = 21;           // one packed component of a register
	localparam int CFG_DATA_W    = 3 * CFG_W;    // widest register
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int D_W           = VAL_W + 4;    // delta before saturation

	localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 2'd2;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [D_W-1:0]   dval_t;

	// mapped sphere centre and the two mapped half axes
	typedef struct packed {
		val_t [2:0] v;
		val_t [2:0] ax;
		val_t [2:0] ay;
	} geom_t;

	// side flags of one divide: sign of result, saturated to one, zero divisor
	typedef struct packed {
		logic neg;
		logic full;
		logic zero;
	} qflag_t;

	typedef struct packed {
		logic        hit;
		dval_t [2:0] d;
	} norm_t;

	localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam logic signed [63:0] VAL_MIN = -(64'sd1 <<< (VAL_W - 1));

	function automatic val_t sat_val(input logic signed [63:0] x);
		logic signed [63:0] y;
		if (x > VAL_MAX) begin
			y = VAL_MAX;
		end else if (x < VAL_MIN) begin
			y = VAL_MIN;
		end else begin
			y = x;
		end
		return y[VAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/src_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried alongside.
// Needs num < den; gives floor(num * 2^QB / den). No package dependency.
`default_nettype none

module src_div #(
	parameter int DW = 48,
	parameter int QB = 16,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic      [QB-1:0] quo,
	output logic      [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [QB];
	logic [DW-1:0] den_s  [QB];
	logic [QB-1:0] quo_s  [QB];
	logic [SW-1:0] side_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW-1:0] r_in;
		logic [DW-1:0] d_in;
		logic [QB-1:0] q_in;
		logic [SW-1:0] sd_in;
		logic [DW:0]   r_sh;
		logic [DW:0]   r_sub;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in  = num;
			assign d_in  = den;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign r_in  = rem_s[k-1];
			assign d_in  = den_s[k-1];
			assign q_in  = quo_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign r_sh  = {r_in, 1'b0};
		assign ge    = r_sh >= {1'b0, d_in};
		assign r_sub = r_sh - {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
				den_s[k]  <= d_in;
				quo_s[k]  <= {q_in[QB-2:0], ge};
				side_s[k] <= sd_in;
			end
		end
	end

	assign quo      = quo_s[QB-1];
	assign side_out = side_s[QB-1];

endmodule

`default_nettype wire

@@ design/src_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband carried alongside.
// root = floor(sqrt(rad)). No package dependency.
`default_nettype none

module src_sqrt #(
	parameter int W  = 16,
	parameter int SW = 1
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [2*W-1:0]  rad,
	input  wire logic [SW-1:0]   side_in,
	output logic      [W-1:0]    root,
	output logic      [SW-1:0]   side_out
);

	logic [2*W-1:0] x_s    [W];
	logic [W+1:0]   rem_s  [W];
	logic [W-1:0]   root_s [W];
	logic [SW-1:0]  side_s [W];

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [2*W-1:0] x_in;
		logic [W+1:0]   r_in;
		logic [W-1:0]   q_in;
		logic [SW-1:0]  sd_in;
		logic [W+3:0]   cur;
		logic [W+3:0]   trial;
		logic [W+3:0]   diff;
		logic           ge;

		if (k == 0) begin : g_first
			assign x_in  = rad;
			assign r_in  = '0;
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign x_in  = x_s[k-1];
			assign r_in  = rem_s[k-1];
			assign q_in  = root_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign cur   = {r_in, x_in[2*W-1 -: 2]};
		assign trial = {2'b00, q_in, 2'b01};
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= {x_in[2*W-3:0], 2'b00};
				rem_s[k]  <= ge ? diff[W+1:0] : cur[W+1:0];
				root_s[k] <= {q_in[W-2:0], ge};
				side_s[k] <= sd_in;
			end
		end
	end

	assign root     = root_s[W-1];
	assign side_out = side_s[W-1];

endmodule

`default_nettype wire

@@ design/sphere_rectangle_collide.sv @@
// Sphere/rectangle collision, pipelined from accept to result.
// Throughput one item per cycle; the whole pipeline holds while a result waits under stall.
// Reset clears the valid bits and the three rectangle registers; datapath registers are not reset.
// Depends on src_pkg, src_div and src_sqrt.
`default_nettype none

module sphere_rectangle_collide #(
	parameter int FRAC_BITS = src_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [src_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [src_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r0c0,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r0c1,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r0c2,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r0c3,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r1c0,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r1c1,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r1c2,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r1c3,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r2c0,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r2c1,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r2c2,
	input  wire logic signed [src_pkg::VAL_W-1:0] xf_r2c3,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 hit,
	output logic signed [src_pkg::VAL_W-1:0]     delta_x,
	output logic signed [src_pkg::VAL_W-1:0]     delta_y,
	output logic signed [src_pkg::VAL_W-1:0]     delta_z
);

	import src_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int PC_W   = VAL_W + CFG_W;                           // matrix x config product
	localparam int SUM_W  = ((VAL_W + F > PC_W) ? VAL_W + F : PC_W) + 2;
	localparam int PRD_W  = 2 * VAL_W;                               // 24x24 products
	localparam int DOT_W  = PRD_W + 2;
	localparam int MAG_W  = PRD_W;                                   // sum of three squares fits
	localparam int PX_W   = F + 2;                                   // projection factor, signed
	localparam int PP_W   = VAL_W + PX_W;
	localparam int TW     = VAL_W + F + 4;
	localparam int SQ_W   = 2 * D_W;
	localparam int MS_W   = SQ_W + 2;
	localparam int NQ_W   = F + 1;
	localparam int RW     = D_W + 2;
	localparam int GSW    = $bits(geom_t) + $bits(qflag_t);
	localparam int QFW    = $bits(qflag_t);
	localparam int NSW    = $bits(norm_t);

	localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(1) <<< (F - 1);
	localparam logic signed [TW-1:0]    HALF_T = TW'(1) <<< (F - 1);

	// ---------------------------------------------------------------
	// Global advance: every stage moves together unless a finished
	// result sits at the output and is being stalled.
	// ---------------------------------------------------------------
	logic en;
	logic vld_s12;

	assign en        = !vld_s12 || !out_stall;
	assign in_stall  = !en;
	assign out_valid = vld_s12;

	// ---------------------------------------------------------------
	// Rectangle registers, to be written only while the block is idle; the block does not enforce this
	// ---------------------------------------------------------------
	logic [CFG_DATA_W-1:0] rect_center_q, half_axis_x_q, half_axis_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_center_q <= '0;
			half_axis_x_q <= '0;
			half_axis_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CENTER: rect_center_q <= cfg_data;
				REG_AXIS_X: half_axis_x_q <= cfg_data;
				REG_AXIS_Y: half_axis_y_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic signed [CFG_W-1:0] cc [3];
	logic signed [CFG_W-1:0] hx [3];
	logic signed [CFG_W-1:0] hy [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cc[j] = rect_center_q[j*CFG_W +: CFG_W];
			hx[j] = half_axis_x_q[j*CFG_W +: CFG_W];
			hy[j] = half_axis_y_q[j*CFG_W +: CFG_W];
		end
	end

	val_t m [3][4];

	assign m[0][0] = xf_r0c0;
	assign m[0][1] = xf_r0c1;
	assign m[0][2] = xf_r0c2;
	assign m[0][3] = xf_r0c3;
	assign m[1][0] = xf_r1c0;
	assign m[1][1] = xf_r1c1;
	assign m[1][2] = xf_r1c2;
	assign m[1][3] = xf_r1c3;
	assign m[2][0] = xf_r2c0;
	assign m[2][1] = xf_r2c1;
	assign m[2][2] = xf_r2c2;
	assign m[2][3] = xf_r2c3;

	// ---------------------------------------------------------------
	// s1: transform products for centre and both half axes
	// ---------------------------------------------------------------
	logic signed [PC_W-1:0] pcc_s1 [3][3];
	logic signed [PC_W-1:0] pcx_s1 [3][3];
	logic signed [PC_W-1:0] pcy_s1 [3][3];
	val_t                   mt_s1  [3];
	logic                   vld_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mt_s1[i] <= m[i][3];
				for (int j = 0; j < 3; j++) begin
					pcc_s1[i][j] <= PC_W'(m[i][j]) * PC_W'(cc[j]);
					pcx_s1[i][j] <= PC_W'(m[i][j]) * PC_W'(hx[j]);
					pcy_s1[i][j] <= PC_W'(m[i][j]) * PC_W'(hy[j]);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// s2: sum, round half up, saturate; sphere centre is the negated
	// mapped rectangle centre
	// ---------------------------------------------------------------
	logic signed [SUM_W-1:0] sc [3];
	logic signed [SUM_W-1:0] sx [3];
	logic signed [SUM_W-1:0] sy [3];
	geom_t                   g_s2;
	logic                    vld_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sc[i] = (SUM_W'(mt_s1[i]) <<< F) + SUM_W'(pcc_s1[i][0])
				+ SUM_W'(pcc_s1[i][1]) + SUM_W'(pcc_s1[i][2]) + HALF_S;
			sx[i] = SUM_W'(pcx_s1[i][0]) + SUM_W'(pcx_s1[i][1])
				+ SUM_W'(pcx_s1[i][2]) + HALF_S;
			sy[i] = SUM_W'(pcy_s1[i][0]) + SUM_W'(pcy_s1[i][1])
				+ SUM_W'(pcy_s1[i][2]) + HALF_S;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				g_s2.v[i]  <= sat_val(-(64'(sat_val(64'(sc[i] >>> F)))));
				g_s2.ax[i] <= sat_val(64'(sx[i] >>> F));
				g_s2.ay[i] <= sat_val(64'(sy[i] >>> F));
			end
		end
	end

	// ---------------------------------------------------------------
	// s3: dot-product and length-squared terms for both axes
	// ---------------------------------------------------------------
	logic signed [PRD_W-1:0] pvx_s3 [3];
	logic signed [PRD_W-1:0] pxx_s3 [3];
	logic signed [PRD_W-1:0] pvy_s3 [3];
	logic signed [PRD_W-1:0] pyy_s3 [3];
	geom_t                   g_s3;
	logic                    vld_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s3 <= g_s2;
			for (int i = 0; i < 3; i++) begin
				pvx_s3[i] <= PRD_W'(g_s2.v[i])  * PRD_W'(g_s2.ax[i]);
				pxx_s3[i] <= PRD_W'(g_s2.ax[i]) * PRD_W'(g_s2.ax[i]);
				pvy_s3[i] <= PRD_W'(g_s2.v[i])  * PRD_W'(g_s2.ay[i]);
				pyy_s3[i] <= PRD_W'(g_s2.ay[i]) * PRD_W'(g_s2.ay[i]);
			end
		end
	end

	// ---------------------------------------------------------------
	// s4: sums
	// ---------------------------------------------------------------
	logic signed [DOT_W-1:0] dotx_s4, doty_s4;
	logic        [MAG_W-1:0] magx_s4, magy_s4;
	geom_t                   g_s4;
	logic                    vld_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4    <= g_s3;
			dotx_s4 <= DOT_W'(pvx_s3[0]) + DOT_W'(pvx_s3[1]) + DOT_W'(pvx_s3[2]);
			doty_s4 <= DOT_W'(pvy_s3[0]) + DOT_W'(pvy_s3[1]) + DOT_W'(pvy_s3[2]);
			magx_s4 <= unsigned'(pxx_s3[0]) + unsigned'(pxx_s3[1]) + unsigned'(pxx_s3[2]);
			magy_s4 <= unsigned'(pyy_s3[0]) + unsigned'(pyy_s3[1]) + unsigned'(pyy_s3[2]);
		end
	end

	// ---------------------------------------------------------------
	// s5: magnitude of the dot product; |dot| >= length squared clamps
	// the factor to one, a degenerate axis forces zero
	// ---------------------------------------------------------------
	logic signed [DOT_W-1:0] adx, ady;
	logic        [MAG_W-1:0] numx_s5, numy_s5, denx_s5, deny_s5;
	qflag_t                  flx_s5, fly_s5;
	geom_t                   g_s5;
	logic                    vld_s5;

	assign adx = (dotx_s4 < 0) ? -dotx_s4 : dotx_s4;
	assign ady = (doty_s4 < 0) ? -doty_s4 : doty_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s5        <= g_s4;
			denx_s5     <= magx_s4;
			deny_s5     <= magy_s4;
			flx_s5.neg  <= dotx_s4 < 0;
			fly_s5.neg  <= doty_s4 < 0;
			flx_s5.full <= adx[MAG_W-1:0] >= magx_s4;
			fly_s5.full <= ady[MAG_W-1:0] >= magy_s4;
			flx_s5.zero <= magx_s4 == '0;
			fly_s5.zero <= magy_s4 == '0;
			numx_s5     <= (adx[MAG_W-1:0] >= magx_s4) ? '0 : adx[MAG_W-1:0];
			numy_s5     <= (ady[MAG_W-1:0] >= magy_s4) ? '0 : ady[MAG_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Projection dividers, F stages
	// ---------------------------------------------------------------
	logic [F-1:0]   qx, qy;
	logic [GSW-1:0] sidex;
	logic [QFW-1:0] sidey;
	geom_t          g_dp;
	qflag_t         flx_dp, fly_dp;
	logic           vld_dp_s [F];

	src_div #(.DW(MAG_W), .QB(F), .SW(GSW)) u_div_px (
		.clk     (clk),
		.en      (en),
		.num     (numx_s5),
		.den     (denx_s5),
		.side_in ({g_s5, flx_s5}),
		.quo     (qx),
		.side_out(sidex)
	);

	src_div #(.DW(MAG_W), .QB(F), .SW(QFW)) u_div_py (
		.clk     (clk),
		.en      (en),
		.num     (numy_s5),
		.den     (deny_s5),
		.side_in (fly_s5),
		.quo     (qy),
		.side_out(sidey)
	);

	assign {g_dp, flx_dp} = sidex;
	assign fly_dp         = sidey;

	// ---------------------------------------------------------------
	// s6: signed projection factors in [-1,1]
	// ---------------------------------------------------------------
	function automatic logic signed [PX_W-1:0] proj_fac(input logic [F-1:0] q,
			input qflag_t fl);
		logic signed [PX_W-1:0] mg;
		mg = fl.full ? (PX_W'(1) <<< F) : signed'(PX_W'(q));
		if (fl.zero) begin
			return '0;
		end
		return fl.neg ? -mg : mg;
	endfunction

	logic signed [PX_W-1:0] px_s6, py_s6;
	geom_t                  g_s6;
	logic                   vld_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s6  <= g_dp;
			px_s6 <= proj_fac(qx, flx_dp);
			py_s6 <= proj_fac(qy, fly_dp);
		end
	end

	// ---------------------------------------------------------------
	// s7: closest-point products
	// ---------------------------------------------------------------
	logic signed [PP_W-1:0] pax_s7 [3];
	logic signed [PP_W-1:0] pay_s7 [3];
	val_t                   v_s7   [3];
	logic                   vld_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s7[i]   <= g_s6.v[i];
				pax_s7[i] <= PP_W'(g_s6.ax[i]) * PP_W'(px_s6);
				pay_s7[i] <= PP_W'(g_s6.ay[i]) * PP_W'(py_s6);
			end
		end
	end

	// ---------------------------------------------------------------
	// s8: delta = centre - closest point, rounded half up
	// ---------------------------------------------------------------
	logic signed [TW-1:0] tt [3];
	dval_t                d_s8 [3];
	logic                 vld_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tt[i] = (TW'(v_s7[i]) <<< F) - (TW'(pax_s7[i]) + TW'(pay_s7[i])) + HALF_T;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s8[i] <= D_W'(tt[i] >>> F);
			end
		end
	end

	// ---------------------------------------------------------------
	// s9: squares; s10: length squared and hit test against one
	// ---------------------------------------------------------------
	logic signed [SQ_W-1:0] sq_s9 [3];
	dval_t                  d_s9  [3];
	logic                   vld_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s9[i]  <= d_s8[i];
				sq_s9[i] <= SQ_W'(d_s8[i]) * SQ_W'(d_s8[i]);
			end
		end
	end

	logic [MS_W-1:0] ms;
	logic [2*F-1:0]  rad_s10;
	norm_t           nrm_s10;
	logic            vld_s10;

	assign ms = MS_W'(unsigned'(sq_s9[0])) + MS_W'(unsigned'(sq_s9[1]))
		+ MS_W'(unsigned'(sq_s9[2]));

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s10     <= ms[2*F-1:0];
			nrm_s10.hit <= ms[MS_W-1:2*F] == '0;
			for (int i = 0; i < 3; i++) begin
				nrm_s10.d[i] <= d_s9[i];
			end
		end
	end

	// ---------------------------------------------------------------
	// Square root of length squared, F stages (only used on a hit,
	// where length squared is below 2^(2F))
	// ---------------------------------------------------------------
	logic [F-1:0]   len_sq;
	logic [NSW-1:0] side_sq;
	norm_t          nrm_sq;
	logic           vld_sq_s [F];

	src_sqrt #(.W(F), .SW(NSW)) u_sqrt (
		.clk     (clk),
		.en      (en),
		.rad     (rad_s10),
		.side_in (nrm_s10),
		.root    (len_sq),
		.side_out(side_sq)
	);

	assign nrm_sq = side_sq;

	// ---------------------------------------------------------------
	// s11: set up the three normalising divides; |d| <= length on a hit
	// so the quotient saturates to exactly one when they are equal
	// ---------------------------------------------------------------
	logic [D_W-1:0] magd [3];
	logic [F-1:0]   num_s11 [3];
	qflag_t         fl_s11  [3];
	logic [F-1:0]   len_s11;
	norm_t          nrm_s11;
	logic           vld_s11;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			magd[i] = (nrm_sq.d[i] < 0) ? unsigned'(-nrm_sq.d[i]) : unsigned'(nrm_sq.d[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s11 <= len_sq;
			nrm_s11 <= nrm_sq;
			for (int i = 0; i < 3; i++) begin
				fl_s11[i].neg  <= nrm_sq.d[i] < 0;
				fl_s11[i].full <= magd[i] >= D_W'(len_sq);
				fl_s11[i].zero <= len_sq == '0;
				num_s11[i]     <= (magd[i] >= D_W'(len_sq)) ? '0 : magd[i][F-1:0];
			end
		end
	end

	// ---------------------------------------------------------------
	// Normalising dividers, one per component, F stages
	// ---------------------------------------------------------------
	logic [F-1:0]       qn [3];
	logic [NSW+QFW-1:0] siden0;
	logic [QFW-1:0]     siden1, siden2;
	norm_t              nrm_dn;
	qflag_t             fl_dn [3];
	logic               vld_dn_s [F];

	src_div #(.DW(F), .QB(F), .SW(NSW + QFW)) u_div_n0 (
		.clk     (clk),
		.en      (en),
		.num     (num_s11[0]),
		.den     (len_s11),
		.side_in ({nrm_s11, fl_s11[0]}),
		.quo     (qn[0]),
		.side_out(siden0)
	);

	src_div #(.DW(F), .QB(F), .SW(QFW)) u_div_n1 (
		.clk     (clk),
		.en      (en),
		.num     (num_s11[1]),
		.den     (len_s11),
		.side_in (fl_s11[1]),
		.quo     (qn[1]),
		.side_out(siden1)
	);

	src_div #(.DW(F), .QB(F), .SW(QFW)) u_div_n2 (
		.clk     (clk),
		.en      (en),
		.num     (num_s11[2]),
		.den     (len_s11),
		.side_in (fl_s11[2]),
		.quo     (qn[2]),
		.side_out(siden2)
	);

	assign {nrm_dn, fl_dn[0]} = siden0;
	assign fl_dn[1]           = siden1;
	assign fl_dn[2]           = siden2;

	// ---------------------------------------------------------------
	// s12 (output register): push-out on a hit, raw delta otherwise;
	// zero length gives a zero push-out
	// ---------------------------------------------------------------
	logic [NQ_W-1:0]      nq  [3];
	logic signed [RW-1:0] nv  [3];
	logic signed [RW-1:0] res [3];
	logic                 hit_s12;
	val_t                 dlt_s12 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nq[i] = fl_dn[i].full ? (NQ_W'(1) << F) : NQ_W'(qn[i]);
			nv[i] = fl_dn[i].neg ? -signed'(RW'(nq[i])) : signed'(RW'(nq[i]));
			if (!nrm_dn.hit) begin
				res[i] = RW'(nrm_dn.d[i]);
			end else if (fl_dn[i].zero) begin
				res[i] = '0;
			end else begin
				res[i] = nv[i] - RW'(nrm_dn.d[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s12 <= nrm_dn.hit;
			for (int i = 0; i < 3; i++) begin
				dlt_s12[i] <= sat_val(64'(res[i]));
			end
		end
	end

	assign hit     = hit_s12;
	assign delta_x = dlt_s12[0];
	assign delta_y = dlt_s12[1];
	assign delta_z = dlt_s12[2];

	// ---------------------------------------------------------------
	// Valid bits, one per stage
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			for (int k = 0; k < F; k++) begin
				vld_dp_s[k] <= 1'b0;
				vld_sq_s[k] <= 1'b0;
				vld_dn_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_dp_s[F-1];
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_sq_s[F-1];
			vld_s12 <= vld_dn_s[F-1];
			vld_dp_s[0] <= vld_s5;
			vld_sq_s[0] <= vld_s10;
			vld_dn_s[0] <= vld_s11;
			for (int k = 1; k < F; k++) begin
				vld_dp_s[k] <= vld_dp_s[k-1];
				vld_sq_s[k] <= vld_sq_s[k-1];
				vld_dn_s[k] <= vld_dn_s[k-1];
			end
		end
	end

endmodule

`default_nettype wire
